// File: src/i2c_ebm_pkg.sv
// Shared types and constants for the I2C memory byte master.
// No dependencies; imported by the front, queue, back and top modules.
`default_nettype none

package i2c_ebm_pkg;

    localparam int unsigned ADDR_W      = 8;
    localparam int unsigned DATA_W      = 8;
    localparam int unsigned DEV_W       = 7;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = 2;
    localparam int unsigned QUEUE_CW    = 3;

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] mem_addr;
        logic [DATA_W-1:0] write_data;
        logic              sda_in;
    } t_cmd;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              busy_res;
        logic              done_res;
        logic [DATA_W-1:0] rd_byte;
        logic              rejected;
    } t_res;

endpackage

`default_nettype wire

// File: src/i2c_ebm_front.sv
// Front end: decodes the function code of an incoming transaction into a queue command.
// Depends on i2c_ebm_pkg.
`default_nettype none

module i2c_ebm_front (
    input  wire logic [1:0]                    i_func,
    input  wire logic [i2c_ebm_pkg::ADDR_W-1:0] i_mem_addr,
    input  wire logic [i2c_ebm_pkg::DATA_W-1:0] i_write_data,
    input  wire logic                          i_sda_in,
    output i2c_ebm_pkg::t_cmd                  o_cmd
);
    import i2c_ebm_pkg::*;

    always_comb begin
        o_cmd.mem_addr   = i_mem_addr;
        o_cmd.write_data = i_write_data;
        o_cmd.sda_in     = i_sda_in;
        unique case (i_func)
            FUNC_TICK:  o_cmd.op = OP_TICK;
            FUNC_WRITE: o_cmd.op = OP_WRITE;
            FUNC_READ:  o_cmd.op = OP_READ;
            default:    o_cmd.op = OP_NONE;
        endcase
    end

endmodule

`default_nettype wire

// File: src/i2c_ebm_queue.sv
// Short command queue between front and back, flip-flop storage.
// Depends on i2c_ebm_pkg.
`default_nettype none

module i2c_ebm_queue (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire i2c_ebm_pkg::t_cmd  i_cmd,
    output logic                    o_not_full,
    input  wire logic               i_pop,
    output logic                    o_not_empty,
    output i2c_ebm_pkg::t_cmd       o_cmd
);
    import i2c_ebm_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0] r_count, n_count;
    logic                w_push, w_pop;

    assign o_not_full  = (r_count != QUEUE_CW'(QUEUE_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_cmd       = r_mem[r_rd_ptr];
    assign w_push      = i_push && o_not_full;
    assign w_pop       = i_pop && o_not_empty;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: src/i2c_ebm_back.sv
// Back end: bus sequencer, one quarter-bit slot per tick command, with result register.
// Depends on i2c_ebm_pkg.
`default_nettype none

module i2c_ebm_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [i2c_ebm_pkg::DEV_W-1:0]  i_dev_addr,
    input  wire logic                          i_cmd_valid,
    input  wire i2c_ebm_pkg::t_cmd             i_cmd,
    output logic                               o_cmd_pop,
    output logic                               o_res_valid,
    input  wire logic                          i_res_ready,
    output i2c_ebm_pkg::t_res                  o_res
);
    import i2c_ebm_pkg::*;

    localparam logic [3:0] PH_IDLE   = 4'd0;
    localparam logic [3:0] PH_START  = 4'd1;
    localparam logic [3:0] PH_DEVW   = 4'd2;
    localparam logic [3:0] PH_ADDR   = 4'd3;
    localparam logic [3:0] PH_DATA   = 4'd4;
    localparam logic [3:0] PH_RSTART = 4'd5;
    localparam logic [3:0] PH_DEVR   = 4'd6;
    localparam logic [3:0] PH_RDBYTE = 4'd7;
    localparam logic [3:0] PH_NACK   = 4'd8;
    localparam logic [3:0] PH_STOP   = 4'd9;

    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;
    localparam logic       RW_WRITE      = 1'b0;
    localparam logic       RW_READ       = 1'b1;

    logic [3:0]        r_phase, n_phase;
    logic [1:0]        r_slot, n_slot;
    logic [3:0]        r_bit_count, n_bit_count;
    logic [DATA_W-1:0] r_tx_shift, n_tx_shift;
    logic [DATA_W-1:0] r_rx_shift, n_rx_shift;
    logic              r_is_read, n_is_read;
    logic [ADDR_W-1:0] r_held_addr, n_held_addr;
    logic [DATA_W-1:0] r_held_data, n_held_data;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic [DATA_W-1:0] r_last_read, n_last_read;
    logic              r_res_valid;
    t_res              r_res, n_res;
    logic              w_done, w_rej;

    assign o_cmd_pop   = i_cmd_valid && (!r_res_valid || i_res_ready);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_phase     = r_phase;
        n_slot      = r_slot;
        n_bit_count = r_bit_count;
        n_tx_shift  = r_tx_shift;
        n_rx_shift  = r_rx_shift;
        n_is_read   = r_is_read;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_scl       = r_scl;
        n_sda       = r_sda;
        n_last_read = r_last_read;
        w_done      = 1'b0;
        w_rej       = 1'b0;

        if (o_cmd_pop) begin
            unique case (i_cmd.op) inside
                OP_WRITE, OP_READ: begin
                    if (r_phase != PH_IDLE) begin
                        w_rej = 1'b1;
                    end else begin
                        n_held_addr = i_cmd.mem_addr;
                        n_held_data = i_cmd.write_data;
                        n_is_read   = (i_cmd.op == OP_READ);
                        n_phase     = PH_START;
                        n_slot      = SLOT_0;
                        n_bit_count = '0;
                        n_tx_shift  = '0;
                    end
                end
                OP_TICK: begin
                    n_slot = r_slot + 2'd1;
                    unique case (r_phase) inside
                        PH_START, PH_RSTART: begin
                            unique case (r_slot)
                                SLOT_0:  n_sda = 1'b1;
                                SLOT_1:  n_scl = 1'b1;
                                SLOT_2:  n_sda = 1'b0;
                                default: begin
                                    n_scl       = 1'b0;
                                    n_slot      = SLOT_0;
                                    n_bit_count = '0;
                                    if (r_phase == PH_START) begin
                                        n_phase    = PH_DEVW;
                                        n_tx_shift = {i_dev_addr, RW_WRITE};
                                    end else begin
                                        n_phase    = PH_DEVR;
                                        n_tx_shift = {i_dev_addr, RW_READ};
                                    end
                                end
                            endcase
                        end
                        PH_DEVW, PH_ADDR, PH_DATA, PH_DEVR: begin
                            if (r_bit_count < BITS_PER_BYTE) begin
                                unique case (r_slot)
                                    SLOT_0:  n_scl = 1'b0;
                                    SLOT_1:  n_sda = r_tx_shift[DATA_W-1];
                                    SLOT_2:  n_scl = 1'b1;
                                    default: begin
                                        n_tx_shift  = {r_tx_shift[DATA_W-2:0], 1'b0};
                                        n_bit_count = r_bit_count + 4'd1;
                                        n_slot      = SLOT_0;
                                    end
                                endcase
                            end else begin
                                unique case (r_slot)
                                    SLOT_0:  n_scl = 1'b0;
                                    SLOT_1:  n_sda = 1'b1;
                                    SLOT_2:  n_scl = 1'b1;
                                    default: begin
                                        n_scl       = 1'b0;
                                        n_slot      = SLOT_0;
                                        n_bit_count = '0;
                                        n_tx_shift  = '0;
                                        unique case (r_phase)
                                            PH_DEVW: begin
                                                n_phase    = PH_ADDR;
                                                n_tx_shift = r_held_addr;
                                            end
                                            PH_ADDR: begin
                                                if (r_is_read) begin
                                                    n_phase = PH_RSTART;
                                                end else begin
                                                    n_phase    = PH_DATA;
                                                    n_tx_shift = r_held_data;
                                                end
                                            end
                                            PH_DATA: n_phase = PH_STOP;
                                            default: n_phase = PH_RDBYTE;
                                        endcase
                                    end
                                endcase
                            end
                        end
                        PH_RDBYTE: begin
                            unique case (r_slot)
                                SLOT_0: begin
                                    n_scl = 1'b0;
                                    n_sda = 1'b1;
                                    if (r_bit_count == '0) begin
                                        n_rx_shift = '0;
                                    end
                                end
                                SLOT_1:  ;
                                SLOT_2:  n_scl = 1'b1;
                                default: begin
                                    n_rx_shift  = {r_rx_shift[DATA_W-2:0], i_cmd.sda_in};
                                    n_bit_count = r_bit_count + 4'd1;
                                    n_slot      = SLOT_0;
                                    if ((r_bit_count + 4'd1) >= BITS_PER_BYTE) begin
                                        n_phase     = PH_NACK;
                                        n_bit_count = '0;
                                        n_tx_shift  = '0;
                                    end
                                end
                            endcase
                        end
                        PH_NACK: begin
                            unique case (r_slot)
                                SLOT_0: begin
                                    n_scl = 1'b0;
                                    n_sda = 1'b1;
                                end
                                SLOT_1:  ;
                                SLOT_2:  n_scl = 1'b1;
                                default: begin
                                    n_scl       = 1'b0;
                                    n_phase     = PH_STOP;
                                    n_slot      = SLOT_0;
                                    n_bit_count = '0;
                                    n_tx_shift  = '0;
                                end
                            endcase
                        end
                        PH_STOP: begin
                            unique case (r_slot)
                                SLOT_0:  n_scl = 1'b0;
                                SLOT_1:  n_sda = 1'b0;
                                SLOT_2:  n_scl = 1'b1;
                                default: begin
                                    n_sda = 1'b1;
                                    if (r_is_read) begin
                                        n_last_read = r_rx_shift;
                                    end
                                    n_phase     = PH_IDLE;
                                    n_slot      = SLOT_0;
                                    n_bit_count = '0;
                                    n_tx_shift  = '0;
                                    w_done      = 1'b1;
                                end
                            endcase
                        end
                        default: n_slot = r_slot;
                    endcase
                end
                default: ;
            endcase
        end

        n_res.scl_level = n_scl;
        n_res.sda_level = n_sda;
        n_res.busy_res  = (n_phase != PH_IDLE);
        n_res.done_res  = w_done;
        n_res.rd_byte   = n_last_read;
        n_res.rejected  = w_rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_slot      <= '0;
            r_bit_count <= '0;
            r_tx_shift  <= '0;
            r_rx_shift  <= '0;
            r_is_read   <= 1'b0;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_last_read <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_slot      <= n_slot;
            r_bit_count <= n_bit_count;
            r_tx_shift  <= n_tx_shift;
            r_rx_shift  <= n_rx_shift;
            r_is_read   <= n_is_read;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_last_read <= n_last_read;
            if (o_cmd_pop) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

// File: src/i2c_eeprom_byte_master.sv
// I2C master for single-byte memory write and random read: top level.
// Depends on i2c_ebm_pkg, i2c_ebm_front, i2c_ebm_queue, i2c_ebm_back.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one transaction per step: a tick,
//   a write request or a read request, with mem_addr, write_data and sda_in.
//   Each tick moves the bus sequence by one quarter-bit slot. Requests made
//   while a transfer runs are dropped and flagged with o_rejected.
//   Output channel (o_valid / i_ready) returns exactly one result per input
//   transaction: SCL and SDA levels, busy, done, last read byte, rejected.
//   Config channel (i_cfg_valid / o_cfg_ready) writes the 7-bit device
//   address; it is always ready and must only be used while idle.
//   The accepted input is written into the queue; the back end then moves it into
//   the result register once any earlier result has been taken.
//   Throughput: one transaction per cycle while results are taken without stalls.
//   A 4-entry command queue absorbs output stalls; o_ready drops when it
//   fills, and results are held until taken.
//   Reset: SCL and SDA released, sequencer idle, device address 0x50, read
//   byte 0, queue and result register empty.
`default_nettype none

module i2c_eeprom_byte_master (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_func,
    input  wire logic [i2c_ebm_pkg::ADDR_W-1:0] i_mem_addr,
    input  wire logic [i2c_ebm_pkg::DATA_W-1:0] i_write_data,
    input  wire logic                          i_sda_in,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_scl_level,
    output logic                               o_sda_level,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic [i2c_ebm_pkg::DATA_W-1:0]      o_rd_byte,
    output logic                               o_rejected,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [i2c_ebm_pkg::DEV_W-1:0]  i_cfg_data
);
    import i2c_ebm_pkg::*;

    localparam logic [DEV_W-1:0] DEV_ADDR_RESET = 7'h50;

    logic             w_cfg_wr;
    logic [DEV_W-1:0] r_dev;
    t_cmd             w_front_cmd, w_queue_cmd;
    logic             w_not_full, w_not_empty, w_pop;
    t_res             w_res;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev <= DEV_ADDR_RESET;
        end else if (w_cfg_wr) begin
            r_dev <= i_cfg_data;
        end
    end

    i2c_ebm_front u_front (
        .i_func       (i_func),
        .i_mem_addr   (i_mem_addr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_cmd        (w_front_cmd)
    );

    assign o_ready = w_not_full;

    i2c_ebm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_valid),
        .i_cmd       (w_front_cmd),
        .o_not_full  (w_not_full),
        .i_pop       (w_pop),
        .o_not_empty (w_not_empty),
        .o_cmd       (w_queue_cmd)
    );

    i2c_ebm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_dev_addr  (r_dev),
        .i_cmd_valid (w_not_empty),
        .i_cmd       (w_queue_cmd),
        .o_cmd_pop   (w_pop),
        .o_res_valid (o_valid),
        .i_res_ready (i_ready),
        .o_res       (w_res)
    );

    assign o_scl_level = w_res.scl_level;
    assign o_sda_level = w_res.sda_level;
    assign o_busy_res  = w_res.busy_res;
    assign o_done_res  = w_res.done_res;
    assign o_rd_byte   = w_res.rd_byte;
    assign o_rejected  = w_res.rejected;

endmodule

`default_nettype wire

// File: src/i2c_ebm_checker.sv
// Port-level checks for the I2C memory byte master, bound to the top level.
// Depends on i2c_ebm_pkg and i2c_eeprom_byte_master.
`default_nettype none

module i2c_ebm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_scl_level,
    input wire logic                          o_sda_level,
    input wire logic                          o_busy_res,
    input wire logic                          o_done_res,
    input wire logic [i2c_ebm_pkg::DATA_W-1:0] o_rd_byte,
    input wire logic                          o_rejected
);
    import i2c_ebm_pkg::*;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done reported while still busy");

    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rejected |-> o_busy_res)
        else $error("request rejected while idle");

    a_idle_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_busy_res |-> o_scl_level && o_sda_level)
        else $error("bus not released while idle");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rd_byte))
        else $error("stalled result changed");

endmodule

bind i2c_eeprom_byte_master i2c_ebm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_scl_level (o_scl_level),
    .o_sda_level (o_sda_level),
    .o_busy_res  (o_busy_res),
    .o_done_res  (o_done_res),
    .o_rd_byte   (o_rd_byte),
    .o_rejected  (o_rejected)
);

`default_nettype wire

// File: verif/i2c_eeprom_byte_master_test.sv
// Testbench for the I2C memory byte master: directed and random bus transfers.
// A scoreboard class predicts the SCL/SDA levels and status of every transaction.
// Depends on i2c_ebm_pkg and i2c_eeprom_byte_master.
`timescale 1ns / 100ps

module i2c_eeprom_byte_master_test;
    import i2c_ebm_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int unsigned ITEM_TARGET = 1800;
    localparam int unsigned IDLE_PCT = 17;
    localparam int unsigned HOLD_CYCLES = 60;

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_DEV_WRITE, ST_MEM_ADDR, ST_DATA,
        ST_RESTART, ST_DEV_READ, ST_READ_BYTE, ST_NACK, ST_STOP
    } t_bus_state;

    class t_eeprom_scoreboard;
        bit [DEV_W-1:0]  dev_addr;
        t_bus_state      state;
        bit [1:0]        slot;
        bit [3:0]        bit_cnt;
        bit [7:0]        tx_byte;
        bit [7:0]        rx_byte;
        bit              rd_op;
        bit [ADDR_W-1:0] addr_hold;
        bit [DATA_W-1:0] data_hold;
        bit              scl;
        bit              sda;
        bit [DATA_W-1:0] last_rd_byte;
        t_res            expected_q[$];
        int unsigned     errors;
        int unsigned     checked;
        int unsigned     rejects;
        int unsigned     transfers;
        int unsigned     reads;

        function void reset_state();
            dev_addr = 7'h50;
            state = ST_IDLE;
            slot = '0;
            bit_cnt = '0;
            tx_byte = '0;
            rx_byte = '0;
            rd_op = 1'b0;
            addr_hold = '0;
            data_hold = '0;
            scl = 1'b1;
            sda = 1'b1;
            last_rd_byte = '0;
        endfunction

        function void set_device_address(bit [DEV_W-1:0] a);
            dev_addr = a;
        endfunction

        function bit busy();
            return state != ST_IDLE;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void load(t_bus_state s, bit [7:0] b);
            state = s;
            slot = '0;
            bit_cnt = '0;
            tx_byte = b;
        endfunction

        // one quarter-bit slot; returns 1 when the stop completes
        function bit step_bus(bit sda_in);
            case (state)
                ST_START, ST_RESTART: begin
                    case (slot)
                        2'd0: sda = 1'b1;
                        2'd1: scl = 1'b1;
                        2'd2: sda = 1'b0;
                        default: begin
                            scl = 1'b0;
                            if (state == ST_START) load(ST_DEV_WRITE, {dev_addr, 1'b0});
                            else load(ST_DEV_READ, {dev_addr, 1'b1});
                            return 1'b0;
                        end
                    endcase
                end
                ST_DEV_WRITE, ST_MEM_ADDR, ST_DATA, ST_DEV_READ: begin
                    if (bit_cnt < 4'd8) begin
                        case (slot)
                            2'd0: scl = 1'b0;
                            2'd1: sda = tx_byte[7];
                            2'd2: scl = 1'b1;
                            default: begin
                                tx_byte = tx_byte << 1;
                                bit_cnt++;
                                slot = '0;
                                return 1'b0;
                            end
                        endcase
                    end else begin
                        // ack slot: sda_in is not looked at
                        case (slot)
                            2'd0: scl = 1'b0;
                            2'd1: sda = 1'b1;
                            2'd2: scl = 1'b1;
                            default: begin
                                scl = 1'b0;
                                case (state)
                                    ST_DEV_WRITE: load(ST_MEM_ADDR, addr_hold);
                                    ST_MEM_ADDR: begin
                                        if (rd_op) load(ST_RESTART, 8'h00);
                                        else load(ST_DATA, data_hold);
                                    end
                                    ST_DATA: load(ST_STOP, 8'h00);
                                    default: load(ST_READ_BYTE, 8'h00);
                                endcase
                                return 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ_BYTE: begin
                    if (slot == 2'd0) begin
                        scl = 1'b0;
                        sda = 1'b1;
                        if (bit_cnt == 4'd0) rx_byte = '0;
                    end else if (slot == 2'd2) begin
                        scl = 1'b1;
                    end else if (slot == 2'd3) begin
                        rx_byte = {rx_byte[6:0], sda_in};
                        bit_cnt++;
                        if (bit_cnt >= 4'd8) load(ST_NACK, 8'h00);
                        else slot = '0;
                        return 1'b0;
                    end
                end
                ST_NACK: begin
                    if (slot == 2'd0) begin
                        scl = 1'b0;
                        sda = 1'b1;
                    end else if (slot == 2'd2) begin
                        scl = 1'b1;
                    end else if (slot == 2'd3) begin
                        scl = 1'b0;
                        load(ST_STOP, 8'h00);
                        return 1'b0;
                    end
                end
                ST_STOP: begin
                    case (slot)
                        2'd0: scl = 1'b0;
                        2'd1: sda = 1'b0;
                        2'd2: scl = 1'b1;
                        default: begin
                            sda = 1'b1;
                            if (rd_op) begin
                                last_rd_byte = rx_byte;
                                reads++;
                            end
                            transfers++;
                            load(ST_IDLE, 8'h00);
                            return 1'b1;
                        end
                    endcase
                end
                default: return 1'b0;
            endcase
            slot = slot + 2'd1;
            return 1'b0;
        endfunction

        // returns 1 when the transaction moved the sequencer
        function bit note_input(logic [1:0] func, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] data, logic sda_in);
            t_res r;
            bit done;
            bit rej;
            bit moved;
            done = 1'b0;
            rej = 1'b0;
            moved = 1'b0;
            if (func == FUNC_TICK) begin
                moved = busy();
                done = step_bus(sda_in);
            end else if (func == FUNC_WRITE || func == FUNC_READ) begin
                if (busy()) begin
                    rej = 1'b1;
                    rejects++;
                end else begin
                    addr_hold = addr;
                    data_hold = data;
                    rd_op = (func == FUNC_READ);
                    load(ST_START, 8'h00);
                    moved = 1'b1;
                end
            end
            r.scl_level = scl;
            r.sda_level = sda;
            r.busy_res = busy();
            r.done_res = done;
            r.rd_byte = last_rd_byte;
            r.rejected = rej;
            expected_q.push_back(r);
            return moved;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (expected_q.size() == 0) begin
                $error("result with no transaction outstanding");
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("scl_level", want.scl_level, got.scl_level);
            compare_field("sda_level", want.sda_level, got.sda_level);
            compare_field("busy_res", want.busy_res, got.busy_res);
            compare_field("done_res", want.done_res, got.done_res);
            compare_field("rd_byte", want.rd_byte, got.rd_byte);
            compare_field("rejected", want.rejected, got.rejected);
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_func = FUNC_TICK;
    logic [ADDR_W-1:0] i_mem_addr = '0;
    logic [DATA_W-1:0] i_write_data = '0;
    logic              i_sda_in = 1'b0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_scl_level;
    logic              o_sda_level;
    logic              o_busy_res;
    logic              o_done_res;
    logic [DATA_W-1:0] o_rd_byte;
    logic              o_rejected;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [DEV_W-1:0]  i_cfg_data = '0;

    t_eeprom_scoreboard sb;
    bit                 sender_gaps = 1'b1;
    bit                 receiver_gaps = 1'b1;
    bit                 rx_hold_req = 1'b0;
    int unsigned        items_moved = 0;
    int unsigned        items_sent = 0;
    int unsigned        cfg_writes = 0;

    i2c_eeprom_byte_master u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_func       (i_func),
        .i_mem_addr   (i_mem_addr),
        .i_write_data (i_write_data),
        .i_sda_in     (i_sda_in),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_scl_level  (o_scl_level),
        .o_sda_level  (o_sda_level),
        .o_busy_res   (o_busy_res),
        .o_done_res   (o_done_res),
        .o_rd_byte    (o_rd_byte),
        .o_rejected   (o_rejected),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_ready <= !receiver_gaps || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_res got;
        if (i_rst_n && o_valid && i_ready) begin
            got.scl_level = o_scl_level;
            got.sda_level = o_sda_level;
            got.busy_res = o_busy_res;
            got.done_res = o_done_res;
            got.rd_byte = o_rd_byte;
            got.rejected = o_rejected;
            sb.check_result(got);
        end
    end

    task automatic send_item(input logic [1:0] func, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic sda);
        i_valid <= 1'b1;
        i_func <= func;
        i_mem_addr <= addr;
        i_write_data <= data;
        i_sda_in <= sda;
        do @(posedge i_clk); while (!o_ready);
        if (sb.note_input(func, addr, data, sda)) items_moved++;
        items_sent++;
        while (sender_gaps && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // ticks until the transfer ends, mixing in dropped requests and unused funcs
    task automatic run_bus_to_idle(input int unsigned noise_pct, input int unsigned ones_pct);
        int unsigned pick;
        while (sb.busy()) begin
            pick = $urandom_range(99);
            if (pick < noise_pct) begin
                case ($urandom_range(2))
                    0: send_item(FUNC_WRITE, 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                    1: send_item(FUNC_READ, 8'($urandom_range(255)),
                                 8'($urandom_range(255)), 1'($urandom_range(1)));
                    default: send_item(FUNC_UNUSED, 8'($urandom_range(255)),
                                       8'($urandom_range(255)), 1'($urandom_range(1)));
                endcase
            end else begin
                send_item(FUNC_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)),
                          $urandom_range(99) < ones_pct);
            end
        end
    endtask

    task automatic wait_results_done();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_device_address(input logic [DEV_W-1:0] a);
        wait_results_done();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_device_address(a);
        cfg_writes++;
    endtask

    initial begin
        int unsigned n;
        logic [DEV_W-1:0] cfg_values[4];
        sb = new;
        sb.reset_state();
        cfg_values = '{7'h00, 7'h7f, 7'h2a, 7'h50};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle corner cases, then a write at the reset address
        send_item(FUNC_TICK, 8'hff, 8'hff, 1'b1);
        send_item(FUNC_TICK, 8'h00, 8'h00, 1'b0);
        send_item(FUNC_UNUSED, 8'hff, 8'h00, 1'b1);
        send_item(FUNC_WRITE, 8'h00, 8'hff, 1'b0);
        send_item(FUNC_READ, 8'hff, 8'h00, 1'b1);
        send_item(FUNC_WRITE, 8'hff, 8'h00, 1'b1);
        send_item(FUNC_UNUSED, 8'h00, 8'hff, 1'b0);
        run_bus_to_idle(0, 50);

        write_device_address(7'h7f);
        send_item(FUNC_READ, 8'hff, 8'h5a, 1'b1);
        send_item(FUNC_WRITE, 8'h00, 8'h00, 1'b0);
        run_bus_to_idle(0, 100);

        write_device_address(7'h00);
        send_item(FUNC_READ, 8'h00, 8'hff, 1'b0);
        run_bus_to_idle(0, 0);
        send_item(FUNC_WRITE, 8'ha5, 8'h00, 1'b1);
        run_bus_to_idle(0, 50);

        n = 0;
        while (items_sent < ITEM_TARGET) begin
            sender_gaps = !(n >= 4 && n <= 6) && n != 2;
            receiver_gaps = !(n >= 4 && n <= 6);
            if (n % 4 == 3) write_device_address(n == 7 ? 7'h7f :
                                                 cfg_values[2'($urandom_range(3))]);
            else if ($urandom_range(2) == 0) wait_results_done();
            repeat ($urandom_range(3)) begin
                send_item($urandom_range(1) ? FUNC_TICK : FUNC_UNUSED,
                          8'($urandom_range(255)), 8'($urandom_range(255)),
                          1'($urandom_range(1)));
            end
            if (n == 2) rx_hold_req = 1'b1;
            send_item($urandom_range(1) ? FUNC_READ : FUNC_WRITE, 8'($urandom_range(255)),
                      8'($urandom_range(255)), 1'($urandom_range(1)));
            run_bus_to_idle(6, 50);
            n++;
        end

        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Ran %0d transactions (%0d advanced the bus): %0d transfers, %0d reads,",
                 items_sent, items_moved, sb.transfers, sb.reads);
        $display("%0d dropped requests, %0d address writes, %0d results checked.",
                 sb.rejects, cfg_writes, sb.checked);
        if (sb.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
